// ===== rtl/core/slnfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the sorted store core.
// No dependencies; imported by the controller, datapath and top level.
package slnfe_pkg;

  // Widths of the word fields, fixed by the interface.
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CountW = 5;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_RESP
  } fsm_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // apply the captured word to the store
  } dp_cmd_t;

endpackage

// ===== rtl/core/sorted_list_nth_from_end_core.sv =====
`timescale 1ns / 1ps
// Sorted store core: keeps up to DEPTH signed 32-bit words in ascending
// order in a row of compare-and-shift cells. An insert word (kind 0) goes in
// ahead of the first held value that is not smaller; a query word (kind 1)
// returns the value at position n from the largest end, n = 1 being the
// largest. Every accepted word gives exactly one result word carrying a
// status (ok, full on an insert into a full store, out of range for a query
// with position 0 or beyond the fill count), the found value (zero unless a
// query succeeds) and the count held afterwards, low 5 bits. Nothing is
// ever removed. Timing: the block handles one word at a time; a word is
// accepted, applied to all cells in parallel in the next cycle, and its
// result is offered in the cycle after that, held there under any output stall,
// paced by the controller's accept/execute/respond sequence. in_stall_o
// is high from acceptance until the result is taken.
// Depends on slnfe_pkg, slnfe_ctrl and slnfe_datapath.
module sorted_list_nth_from_end_core
  import slnfe_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input word channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic        [PosW-1:0]   position_i,
  // result word channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic        [1:0]        status_o,
  output logic signed [ValueW-1:0] found_value_o,
  output logic        [CountW-1:0] stored_count_o
);

  dp_cmd_t cmd;

  slnfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  slnfe_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .status_o       (status_o),
    .found_value_o  (found_value_o),
    .stored_count_o (stored_count_o)
  );

endmodule

// ===== rtl/core/slnfe_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing controller for the sorted store core: one word at a time.
// Depends on slnfe_pkg.
module slnfe_ctrl
  import slnfe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = FSM_RESP;
      end
      FSM_RESP: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/slnfe_datapath.sv =====
`timescale 1ns / 1ps
// Row of compare-and-shift cells, fill count and result registers.
// Depends on slnfe_pkg; driven by slnfe_ctrl commands.
module slnfe_datapath
  import slnfe_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  input  logic                     kind_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic        [PosW-1:0]   position_i,
  output logic        [1:0]        status_o,
  output logic signed [ValueW-1:0] found_value_o,
  output logic        [CountW-1:0] stored_count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  // captured word
  kind_e                     kind_q;
  logic signed [ValueW-1:0]  value_q;
  logic        [PosW-1:0]    pos_q;

  logic        [CntW-1:0]    count_q, count_d;
  logic signed [ValueW-1:0]  cell_q [DEPTH];
  logic        [DEPTH-1:0]   lt;

  status_e                   status_q, status_d;
  logic signed [ValueW-1:0]  found_q, found_d;
  logic        [CountW-1:0]  scount_q;

  logic                      full;
  logic                      do_ins;
  logic        [CmpW-1:0]    cnt_ext, pos_ext, rd_ptr;
  logic        [IdxW-1:0]    rd_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_e'(kind_i);
      value_q <= value_i;
      pos_q   <= position_i;
    end
  end

  assign full   = (count_q == CntW'(DEPTH));
  assign do_ins = cmd_i.exec && (kind_q == KIND_INSERT) && !full;

  // Each cell keeps its word while it is below the new value, else takes
  // the new value at the boundary or its left neighbour's word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign lt[i] = (CntW'(i) < count_q) && (cell_q[i] < value_q);

    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (do_ins && !lt[0]) begin
          cell_q[0] <= value_q;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (do_ins && !lt[i]) begin
          cell_q[i] <= lt[i-1] ? value_q : cell_q[i-1];
        end
      end
    end
  end

  assign cnt_ext = CmpW'(count_q);
  assign pos_ext = CmpW'(pos_q);
  assign rd_ptr  = cnt_ext - pos_ext;
  assign rd_idx  = rd_ptr[IdxW-1:0];

  always_comb begin
    count_d  = count_q;
    status_d = STAT_OK;
    found_d  = '0;
    unique case (kind_q)
      KIND_INSERT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      KIND_QUERY: begin
        if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
          status_d = STAT_RANGE;
        end else begin
          found_d = cell_q[rd_idx];
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      found_q  <= found_d;
      scount_q <= CountW'(CmpW'(count_d));
    end
  end

  assign status_o       = status_q;
  assign found_value_o  = found_q;
  assign stored_count_o = scount_q;

endmodule

// ===== rtl/core/slnfe_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sorted store core, bound to the top level.
// Depends on slnfe_pkg and sorted_list_nth_from_end_core.
module slnfe_checker
  import slnfe_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic        [1:0]        status_o,
  input logic signed [ValueW-1:0] found_value_o,
  input logic        [CountW-1:0] stored_count_o
);

  localparam logic [CountW-1:0] FullCnt = CountW'(DEPTH);

  // one word in flight: after an accept the input side stalls
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a word is in flight");

  // failures never carry a value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (found_value_o == '0))
    else $error("non-zero value with failing status");

  // full is only reported with the store at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_FULL)) |-> (stored_count_o == FullCnt))
    else $error("full status with count below capacity");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(found_value_o)))
    else $error("result word changed under stall");

endmodule

bind sorted_list_nth_from_end_core slnfe_checker #(
  .DEPTH (DEPTH)
) u_slnfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .found_value_o  (found_value_o),
  .stored_count_o (stored_count_o)
);
